[hdl/dfs_pkg.sv]
// Package: shared constants and types for the depth-first search arc classifier.
`default_nettype none
package dfs_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxArcs     = 256;
    localparam int VW = $clog2(MaxVertices);
    localparam int AW = $clog2(MaxArcs);
    localparam int CW = AW + 1;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_RUN   = 3'd1;
    localparam logic [2:0] OP_RDV   = 3'd2;
    localparam logic [2:0] OP_RDA   = 3'd3;
    localparam logic [2:0] OP_CLR   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] K_TREE   = 2'd0;
    localparam logic [1:0] K_BACK   = 2'd1;
    localparam logic [1:0] K_FWD    = 2'd2;
    localparam logic [1:0] K_CROSS  = 2'd3;

    localparam logic [1:0] C_WHITE  = 2'd0;
    localparam logic [1:0] C_GRAY   = 2'd1;
    localparam logic [1:0] C_BLACK  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,   // take requests
        S_READ,   // memory read for a read request in flight
        S_CLRV,   // clear vertex records
        S_STALE,  // mark stale arcs
        S_ROOT,   // read color of next root candidate
        S_RCHK,   // open the root if it is still white
        S_SCAN,   // issue arc read at cursor, or finish the top vertex
        S_CHK,    // test the arc, read its target record
        S_CLASS,  // classify with target record
        S_POP,    // read new stack top after a finish
        S_TOP,    // load stack top, read its open stamp
        S_UOPEN,  // load open stamp of the stack top
        S_RESP    // present result
    } t_state;
endpackage
`default_nettype wire

[hdl/dfs_edge_classifier_unit.sv]
// Top level: arc table, vertex records and search sequencer of the classifier.
// After reset a clearing pass over all MaxVertices vertex records runs with o_ready low.
// Add, clear and unknown requests pass through S_RESP before their result is registered,
// read requests through S_READ first; the next request is taken in the cycle after the
// result is taken. A run request walks the stored graph: a clear pass over all records,
// a stale mark pass over every stored arc, a color check of each root candidate, then
// for each arc at a cursor a read and a test, a classification with the target record
// for each followed arc, a finish step per vertex and a reload of the stack top after
// each finish that leaves the stack non-empty. Every vertex scans the table once, so
// run time grows with vertices times stored arcs, bounded by the single arc read port.
// Results wait in an output register that blocks the input until taken.
`default_nettype none
module dfs_edge_classifier_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [5:0]  i_origin_vertex,
    input  wire logic [5:0]  i_target_vertex,
    input  wire logic [7:0]  i_read_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [1:0]       o_arc_kind,
    output logic [7:0]       o_discovery_time,
    output logic [7:0]       o_finish_time,
    output logic [5:0]       o_parent_vertex,
    output logic             o_has_parent,
    output logic [8:0]       o_stored_arcs,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);
    localparam int VW = dfs_pkg::VW;
    localparam int AW = dfs_pkg::AW;
    localparam int CW = dfs_pkg::CW;

    // memories
    logic [VW-1:0] m_src [dfs_pkg::MaxArcs];
    logic [VW-1:0] m_dst [dfs_pkg::MaxArcs];
    logic [1:0]    m_cls [dfs_pkg::MaxArcs];
    logic [1:0]    m_col [dfs_pkg::MaxVertices];
    logic [7:0]    m_opn [dfs_pkg::MaxVertices];
    logic [7:0]    m_cls_t [dfs_pkg::MaxVertices];
    logic [VW:0]   m_par [dfs_pkg::MaxVertices];
    logic [VW-1:0] m_stk_v [dfs_pkg::MaxVertices];
    logic [CW-1:0] m_stk_k [dfs_pkg::MaxVertices];

    dfs_pkg::t_state r_state, n_state;
    logic [6:0]    r_vcnt;
    logic [CW-1:0] r_total;
    logic [2:0]    r_op;
    logic [7:0]    r_idx;
    logic [VW:0]   r_cnt;        // vertex sweep / root counter
    logic [CW-1:0] r_k;          // arc cursor
    logic [VW:0]   r_depth;
    logic [VW-1:0] r_u;
    logic [7:0]    r_uopen;
    logic [8:0]    r_clock;
    logic          r_boot;       // clearing pass after reset, no result
    logic          r_ovalid;
    logic [1:0]    r_status, r_kind;
    logic [7:0]    r_disc, r_fin;
    logic [5:0]    r_par;
    logic          r_haspar;

    // registered memory read data
    logic [VW-1:0] q_src, q_dst;
    logic [1:0]    q_cls, q_col;
    logic [7:0]    q_opn, q_ctm;
    logic [VW:0]   q_par;
    logic [VW-1:0] q_sv;
    logic [CW-1:0] q_sk;

    logic [VW:0] live_n;
    assign live_n = (r_vcnt > 7'(dfs_pkg::MaxVertices)) ? (VW+1)'(dfs_pkg::MaxVertices)
                                                       : (VW+1)'(r_vcnt);

    logic [VW:0] depth_m1;
    assign depth_m1 = r_depth - 1'b1;

    // address selection
    logic [AW-1:0] arc_ra;
    logic [VW-1:0] vtx_ra;
    logic [VW-1:0] stk_ra;
    always_comb begin
        arc_ra = r_k[AW-1:0];
        stk_ra = depth_m1[VW-1:0];
        unique case (r_state)
            dfs_pkg::S_IDLE: vtx_ra = i_read_index[VW-1:0];
            dfs_pkg::S_ROOT: vtx_ra = r_cnt[VW-1:0];
            dfs_pkg::S_TOP:  vtx_ra = q_sv;
            default:         vtx_ra = q_dst;
        endcase
        if (r_state == dfs_pkg::S_IDLE) arc_ra = i_read_index[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        q_src <= m_src[arc_ra];
        q_dst <= m_dst[arc_ra];
        q_cls <= m_cls[arc_ra];
        q_col <= m_col[vtx_ra];
        q_opn <= m_opn[vtx_ra];
        q_ctm <= m_cls_t[vtx_ra];
        q_par <= m_par[vtx_ra];
        q_sv  <= m_stk_v[stk_ra];
        q_sk  <= m_stk_k[stk_ra];
    end

    logic in_fire, out_fire;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_ovalid && i_ready;
    assign o_ready  = (r_state == dfs_pkg::S_IDLE) && !r_ovalid;
    assign o_cfg_ready = (r_state == dfs_pkg::S_IDLE);

    logic src_ok, dst_ok;
    assign src_ok = (VW+1)'(i_origin_vertex) < live_n;
    assign dst_ok = (VW+1)'(i_target_vertex) < live_n;

    // arc being examined qualifies for the walk
    logic arc_hit;
    assign arc_hit = (q_src == r_u) && ((VW+1)'(q_dst) < live_n);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dfs_pkg::S_IDLE: if (in_fire) begin
                unique case (i_opcode)
                    dfs_pkg::OP_RUN: n_state = dfs_pkg::S_CLRV;
                    dfs_pkg::OP_RDV, dfs_pkg::OP_RDA: n_state = dfs_pkg::S_READ;
                    default: n_state = dfs_pkg::S_RESP;
                endcase
            end
            dfs_pkg::S_READ:  n_state = dfs_pkg::S_RESP;
            dfs_pkg::S_CLRV:  if (r_cnt == (VW+1)'(dfs_pkg::MaxVertices - 1))
                                  n_state = r_boot ? dfs_pkg::S_IDLE : dfs_pkg::S_STALE;
            dfs_pkg::S_STALE: if (r_k >= r_total) n_state = dfs_pkg::S_ROOT;
            dfs_pkg::S_ROOT:  n_state = (r_cnt >= live_n) ? dfs_pkg::S_RESP
                                                          : dfs_pkg::S_RCHK;
            dfs_pkg::S_RCHK:  n_state = (q_col == dfs_pkg::C_WHITE) ? dfs_pkg::S_SCAN
                                                                    : dfs_pkg::S_ROOT;
            dfs_pkg::S_SCAN: begin
                if (r_k >= r_total)
                    n_state = (r_depth == (VW+1)'(1)) ? dfs_pkg::S_ROOT : dfs_pkg::S_POP;
                else
                    n_state = dfs_pkg::S_CHK;
            end
            dfs_pkg::S_CHK:   n_state = arc_hit ? dfs_pkg::S_CLASS : dfs_pkg::S_SCAN;
            dfs_pkg::S_CLASS: n_state = dfs_pkg::S_SCAN;
            dfs_pkg::S_POP:   n_state = dfs_pkg::S_TOP;
            dfs_pkg::S_TOP:   n_state = dfs_pkg::S_UOPEN;
            dfs_pkg::S_UOPEN: n_state = dfs_pkg::S_SCAN;
            dfs_pkg::S_RESP:  n_state = dfs_pkg::S_IDLE;
            default:          n_state = dfs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dfs_pkg::S_CLRV;
        else          r_state <= n_state;
    end

    // datapath and memory writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt   <= 7'(dfs_pkg::MaxVertices);
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_k      <= '0;
            r_depth  <= '0;
            r_clock  <= '0;
            r_boot   <= 1'b1;
            r_status <= dfs_pkg::ST_OK;
            r_kind   <= '0;
            r_disc   <= '0;
            r_fin    <= '0;
            r_par    <= '0;
            r_haspar <= 1'b0;
        end else begin
            if (out_fire) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_vcnt <= i_cfg_data;
            unique case (r_state)
                dfs_pkg::S_IDLE: if (in_fire) begin
                    r_op <= i_opcode; r_idx <= i_read_index;
                    r_status <= dfs_pkg::ST_OK; r_kind <= '0;
                    r_disc <= '0; r_fin <= '0; r_par <= '0; r_haspar <= 1'b0;
                    r_cnt <= '0; r_k <= '0;
                    unique case (i_opcode)
                        dfs_pkg::OP_ADD: begin
                            if (!src_ok || !dst_ok) r_status <= dfs_pkg::ST_RANGE;
                            else if (r_total >= CW'(dfs_pkg::MaxArcs))
                                r_status <= dfs_pkg::ST_FULL;
                            else begin
                                m_src[r_total[AW-1:0]] <= i_origin_vertex[VW-1:0];
                                m_dst[r_total[AW-1:0]] <= i_target_vertex[VW-1:0];
                                m_cls[r_total[AW-1:0]] <= dfs_pkg::K_TREE;
                                r_total <= r_total + 1'b1;
                            end
                        end
                        dfs_pkg::OP_CLR: r_total <= '0;
                        dfs_pkg::OP_RUN, dfs_pkg::OP_RDV, dfs_pkg::OP_RDA: ;
                        default: r_status <= dfs_pkg::ST_RANGE;
                    endcase
                end
                dfs_pkg::S_READ: begin
                    if (r_op == dfs_pkg::OP_RDV) begin
                        if (r_idx >= {1'b0, live_n})
                            r_status <= dfs_pkg::ST_RANGE;
                        else begin
                            r_disc <= q_opn; r_fin <= q_ctm;
                            r_par <= 6'(q_par[VW-1:0]); r_haspar <= !q_par[VW];
                        end
                    end else begin
                        if (CW'(r_idx) >= r_total) r_status <= dfs_pkg::ST_RANGE;
                        else r_kind <= q_cls;
                    end
                end
                dfs_pkg::S_CLRV: begin
                    m_col[r_cnt[VW-1:0]]   <= dfs_pkg::C_WHITE;
                    m_opn[r_cnt[VW-1:0]]   <= '0;
                    m_cls_t[r_cnt[VW-1:0]] <= '0;
                    m_par[r_cnt[VW-1:0]]   <= {1'b1, {VW{1'b0}}};
                    r_cnt <= r_cnt + 1'b1;
                    r_depth <= '0; r_clock <= '0;
                    if (r_cnt == (VW+1)'(dfs_pkg::MaxVertices - 1)) begin
                        r_cnt  <= '0;
                        r_boot <= 1'b0;
                    end
                end
                dfs_pkg::S_STALE: begin
                    // read data lags the cursor by one, so mark arc r_k-1
                    if (r_k != '0 && ((VW+1)'(q_src) >= live_n || (VW+1)'(q_dst) >= live_n))
                        m_cls[AW'(r_k - 1'b1)] <= dfs_pkg::K_CROSS;
                    r_k <= r_k + 1'b1;
                end
                dfs_pkg::S_ROOT: ;
                dfs_pkg::S_RCHK: begin
                    // q_col holds color of vertex r_cnt read in the previous cycle
                    r_cnt <= r_cnt + 1'b1;
                    if (q_col == dfs_pkg::C_WHITE) begin
                        r_clock <= r_clock + 1'b1;
                        m_opn[r_cnt[VW-1:0]] <= 8'(r_clock + 1'b1);
                        m_col[r_cnt[VW-1:0]] <= dfs_pkg::C_GRAY;
                        m_stk_v[0] <= r_cnt[VW-1:0];
                        r_depth <= (VW+1)'(1);
                        r_u <= r_cnt[VW-1:0];
                        r_uopen <= 8'(r_clock + 1'b1);
                        r_k <= '0;
                    end
                end
                dfs_pkg::S_SCAN: begin
                    // no arc left for the top vertex: finish it and pop
                    if (r_k >= r_total) begin
                        r_clock <= r_clock + 1'b1;
                        m_cls_t[r_u] <= 8'(r_clock + 1'b1);
                        m_col[r_u] <= dfs_pkg::C_BLACK;
                        r_depth <= depth_m1;
                    end
                end
                dfs_pkg::S_CHK: r_k <= r_k + 1'b1;
                dfs_pkg::S_CLASS: begin
                    // classify arc r_k-1 by the color of its target
                    if (q_col == dfs_pkg::C_WHITE) begin
                        m_cls[AW'(r_k - 1'b1)] <= dfs_pkg::K_TREE;
                        m_par[q_dst] <= {1'b0, r_u};
                        r_clock <= r_clock + 1'b1;
                        m_opn[q_dst] <= 8'(r_clock + 1'b1);
                        m_col[q_dst] <= dfs_pkg::C_GRAY;
                        m_stk_k[depth_m1[VW-1:0]] <= r_k;
                        m_stk_v[r_depth[VW-1:0]] <= q_dst;
                        r_depth <= r_depth + 1'b1;
                        r_u <= q_dst; r_uopen <= 8'(r_clock + 1'b1); r_k <= '0;
                    end else if (q_col == dfs_pkg::C_GRAY)
                        m_cls[AW'(r_k - 1'b1)] <= dfs_pkg::K_BACK;
                    else
                        m_cls[AW'(r_k - 1'b1)] <= (q_opn > r_uopen) ? dfs_pkg::K_FWD
                                                                    : dfs_pkg::K_CROSS;
                end
                dfs_pkg::S_POP: ;
                dfs_pkg::S_TOP: begin
                    r_u <= q_sv; r_k <= q_sk;
                end
                dfs_pkg::S_UOPEN: r_uopen <= q_opn;
                dfs_pkg::S_RESP: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_arc_kind       = r_kind;
    assign o_discovery_time = r_disc;
    assign o_finish_time    = r_fin;
    assign o_parent_vertex  = r_par;
    assign o_has_parent     = r_haspar;
    assign o_stored_arcs    = r_total;
endmodule
`default_nettype wire

[verif/tb_dfs_edge_classifier_unit.sv]
// Testbench for the depth-first search arc classifier: directed and random requests.
`default_nettype none
module tb_dfs_edge_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // highest opcode value the port can carry; values above OP_CLR are unknown
    localparam logic [2:0] OP_LAST = 3'd7;
    localparam int NoParent = -1;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [7:0] disc;
        logic [7:0] fin;
        logic [5:0] par;
        logic       has_par;
        logic [8:0] stored;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [2:0] i_opcode = '0;
    logic [5:0] i_origin_vertex = '0;
    logic [5:0] i_target_vertex = '0;
    logic [7:0] i_read_index = '0;
    logic       i_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [6:0] i_cfg_data = '0;
    logic       o_ready, o_valid, o_has_parent, o_cfg_ready;
    logic [1:0] o_status, o_arc_kind;
    logic [7:0] o_discovery_time, o_finish_time;
    logic [5:0] o_parent_vertex;
    logic [8:0] o_stored_arcs;

    dfs_edge_classifier_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_origin_vertex(i_origin_vertex),
        .i_target_vertex(i_target_vertex), .i_read_index(i_read_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_arc_kind(o_arc_kind),
        .o_discovery_time(o_discovery_time), .o_finish_time(o_finish_time),
        .o_parent_vertex(o_parent_vertex), .o_has_parent(o_has_parent),
        .o_stored_arcs(o_stored_arcs),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the classifier
    int       arc_src [dfs_pkg::MaxArcs];
    int       arc_dst [dfs_pkg::MaxArcs];
    int       arc_cls [dfs_pkg::MaxArcs];
    int       arc_cnt;
    int       vcount;
    int       vtx_color [dfs_pkg::MaxVertices];
    int       vtx_disc [dfs_pkg::MaxVertices];
    int       vtx_fin [dfs_pkg::MaxVertices];
    int       vtx_par [dfs_pkg::MaxVertices];
    int       walk_vtx [dfs_pkg::MaxVertices];
    int       walk_pos [dfs_pkg::MaxVertices];
    int       walk_depth;
    int       stamp;

    t_answer  answer_q[$];
    int       errors;
    int       n_requests;
    int       n_answers;
    int       n_runs;
    int       n_cfg;
    bit       idle_on;
    int       hold_left;
    int       stall_left;

    function automatic int live_count();
        return (vcount > dfs_pkg::MaxVertices) ? dfs_pkg::MaxVertices : vcount;
    endfunction

    function automatic void open_vtx(int u);
        if (walk_depth >= dfs_pkg::MaxVertices) return;
        stamp++;
        vtx_disc[u] = stamp;
        vtx_color[u] = dfs_pkg::C_GRAY;
        walk_vtx[walk_depth] = u;
        walk_pos[walk_depth] = 0;
        walk_depth++;
    endfunction

    // depth-first walk over the stored arcs, classifying each one
    function automatic void search_graph();
        int n;
        int u, k, t, top;
        n = live_count();
        for (int v = 0; v < dfs_pkg::MaxVertices; v++) begin
            vtx_color[v] = dfs_pkg::C_WHITE;
            vtx_disc[v] = 0;
            vtx_fin[v] = 0;
            vtx_par[v] = NoParent;
        end
        walk_depth = 0;
        stamp = 0;
        for (int i = 0; i < arc_cnt; i++)
            if (arc_src[i] >= n || arc_dst[i] >= n) arc_cls[i] = dfs_pkg::K_CROSS;
        for (int r = 0; r < n; r++) begin
            if (vtx_color[r] != dfs_pkg::C_WHITE) continue;
            open_vtx(r);
            while (walk_depth > 0) begin
                top = walk_depth - 1;
                u = walk_vtx[top];
                k = walk_pos[top];
                while (k < arc_cnt && !(arc_src[k] == u && arc_dst[k] < n)) k++;
                if (k >= arc_cnt) begin
                    stamp++;
                    vtx_fin[u] = stamp;
                    vtx_color[u] = dfs_pkg::C_BLACK;
                    walk_depth--;
                    continue;
                end
                walk_pos[top] = k + 1;
                t = arc_dst[k];
                if (vtx_color[t] == dfs_pkg::C_WHITE) begin
                    arc_cls[k] = dfs_pkg::K_TREE;
                    vtx_par[t] = u;
                    open_vtx(t);
                end else if (vtx_color[t] == dfs_pkg::C_GRAY) begin
                    arc_cls[k] = dfs_pkg::K_BACK;
                end else begin
                    arc_cls[k] = (vtx_disc[t] > vtx_disc[u]) ? dfs_pkg::K_FWD
                                                             : dfs_pkg::K_CROSS;
                end
            end
        end
    endfunction

    // apply one request to the shadow state and return the answer it must give
    function automatic t_answer apply_request(logic [2:0] op, int src, int dst, int idx);
        t_answer a;
        int n;
        a = '0;
        n = live_count();
        case (op)
            dfs_pkg::OP_ADD: begin
                if (src >= n || dst >= n) a.status = dfs_pkg::ST_RANGE;
                else if (arc_cnt >= dfs_pkg::MaxArcs) a.status = dfs_pkg::ST_FULL;
                else begin
                    arc_src[arc_cnt] = src;
                    arc_dst[arc_cnt] = dst;
                    arc_cls[arc_cnt] = dfs_pkg::K_TREE;
                    arc_cnt++;
                end
            end
            dfs_pkg::OP_RUN: search_graph();
            dfs_pkg::OP_RDV: begin
                if (idx >= n) a.status = dfs_pkg::ST_RANGE;
                else begin
                    a.disc = vtx_disc[idx][7:0];
                    a.fin = vtx_fin[idx][7:0];
                    if (vtx_par[idx] != NoParent) begin
                        a.par = vtx_par[idx][5:0];
                        a.has_par = 1'b1;
                    end
                end
            end
            dfs_pkg::OP_RDA: begin
                if (idx >= arc_cnt) a.status = dfs_pkg::ST_RANGE;
                else a.kind = arc_cls[idx][1:0];
            end
            dfs_pkg::OP_CLR: arc_cnt = 0;
            default: a.status = dfs_pkg::ST_RANGE;
        endcase
        a.stored = arc_cnt[8:0];
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (answer %0d)", what, got, want, n_answers);
        errors++;
    endtask

    // offer one request, wait for acceptance, then record its answer
    task automatic send_req(logic [2:0] op, int src, int dst, int idx);
        int gap;
        t_answer want;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_origin_vertex <= src[5:0];
        i_target_vertex <= dst[5:0];
        i_read_index <= idx[7:0];
        do @(posedge i_clk); while (!o_ready);
        want = apply_request(op, src, dst, idx);
        answer_q = {answer_q, want};
        if (op == dfs_pkg::OP_RUN) n_runs++;
        n_requests++;
    endtask

    // hold the sender until every pending answer is back
    task automatic drain();
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_vcount(int value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        vcount = value;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // check each answer against the oldest pending one, and draw the stalls
    initial begin
        t_answer w;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                n_answers++;
                if (answer_q.size() == 0) begin
                    report("unexpected answer", 1, 0);
                end else begin
                    w = answer_q.pop_front();
                    if (o_status != w.status) report("status", o_status, w.status);
                    if (o_arc_kind != w.kind) report("arc_kind", o_arc_kind, w.kind);
                    if (o_discovery_time != w.disc)
                        report("discovery", o_discovery_time, w.disc);
                    if (o_finish_time != w.fin) report("finish", o_finish_time, w.fin);
                    if (o_parent_vertex != w.par) report("parent", o_parent_vertex, w.par);
                    if (o_has_parent != w.has_par)
                        report("has_parent", o_has_parent, w.has_par);
                    if (o_stored_arcs != w.stored) report("stored", o_stored_arcs, w.stored);
                end
                stall_left = idle_on ? $urandom_range(0, 14) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // small graph with every arc class, a self loop, reads before and after the run
    task automatic test_directed();
        send_req(dfs_pkg::OP_RDV, 0, 0, 0);
        send_req(dfs_pkg::OP_RDA, 0, 0, 0);
        send_req(dfs_pkg::OP_ADD, 0, 1, 0);
        send_req(dfs_pkg::OP_ADD, 1, 2, 0);
        send_req(dfs_pkg::OP_ADD, 2, 0, 0);
        send_req(dfs_pkg::OP_ADD, 0, 2, 0);
        send_req(dfs_pkg::OP_ADD, 3, 1, 0);
        send_req(dfs_pkg::OP_ADD, 3, 3, 0);
        send_req(dfs_pkg::OP_ADD, 63, 0, 0);
        send_req(dfs_pkg::OP_RDA, 0, 0, 0);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        for (int i = 0; i < 7; i++) send_req(dfs_pkg::OP_RDA, 0, 0, i);
        send_req(dfs_pkg::OP_RDV, 0, 0, 2);
        send_req(dfs_pkg::OP_RDV, 0, 0, 63);
        send_req(dfs_pkg::OP_RDA, 0, 0, 255);
        for (int op = int'(dfs_pkg::OP_CLR) + 1; op <= int'(OP_LAST); op++)
            send_req(3'(op), 63, 63, 255);
        send_req(dfs_pkg::OP_CLR, 0, 0, 0);
        drain();
    endtask

    // empty graph, a vertex count beyond the limit, and a tiny graph
    task automatic test_vcount_extremes();
        write_vcount(0);
        send_req(dfs_pkg::OP_ADD, 0, 0, 0);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        send_req(dfs_pkg::OP_RDV, 0, 0, 0);
        write_vcount(127);
        send_req(dfs_pkg::OP_ADD, 63, 62, 0);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        send_req(dfs_pkg::OP_RDV, 0, 0, 63);
        write_vcount(1);
        send_req(dfs_pkg::OP_ADD, 0, 1, 0);
        send_req(dfs_pkg::OP_ADD, 0, 0, 0);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        send_req(dfs_pkg::OP_RDA, 0, 0, 0);
        send_req(dfs_pkg::OP_RDA, 0, 0, 1);
        send_req(dfs_pkg::OP_CLR, 0, 0, 0);
        write_vcount(64);
    endtask

    // arcs left behind when the vertex count shrinks become cross and are skipped
    task automatic test_stale_arcs();
        send_req(dfs_pkg::OP_ADD, 0, 40, 0);
        send_req(dfs_pkg::OP_ADD, 40, 1, 0);
        send_req(dfs_pkg::OP_ADD, 0, 1, 0);
        send_req(dfs_pkg::OP_ADD, 1, 0, 0);
        write_vcount(8);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_req(dfs_pkg::OP_RDA, 0, 0, i);
        send_req(dfs_pkg::OP_RDV, 0, 0, 1);
        send_req(dfs_pkg::OP_CLR, 0, 0, 0);
        write_vcount(64);
    endtask

    // fill the arc table, overflow it, and search the full table
    task automatic test_full_table();
        for (int i = 0; i < dfs_pkg::MaxArcs; i++)
            send_req(dfs_pkg::OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63), 0);
        send_req(dfs_pkg::OP_ADD, 5, 6, 0);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        for (int i = 0; i < 24; i++)
            send_req(dfs_pkg::OP_RDA, 0, 0, $urandom_range(0, 255));
        for (int i = 0; i < 8; i++)
            send_req(dfs_pkg::OP_RDV, 0, 0, $urandom_range(0, 63));
        send_req(dfs_pkg::OP_CLR, 0, 0, 0);
        drain();
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits
    task automatic test_backpressure();
        bit saved;
        saved = idle_on;
        idle_on = 1'b0;
        hold_left = 300;
        for (int i = 0; i < 30; i++)
            send_req(i % 3 == 0 ? dfs_pkg::OP_RDA : dfs_pkg::OP_ADD, i % 8, (i * 3) % 8,
                     i % 12);
        send_req(dfs_pkg::OP_RUN, 0, 0, 0);
        drain();
        idle_on = saved;
    endtask

    // random graphs: optional clear, arcs, a run, then reads, with some noise
    task automatic test_random(int target);
        int n, m, pick;
        while (n_requests < target) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 9);
                write_vcount(pick == 0 ? $urandom_range(0, 127)
                             : pick < 3 ? 64 : $urandom_range(1, 12));
            end
            if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
            n = live_count();
            if ($urandom_range(0, 9) < 7) send_req(dfs_pkg::OP_CLR, 0, 0, 0);
            m = $urandom_range(1, 20);
            for (int i = 0; i < m; i++) begin
                if (n == 0 || $urandom_range(0, 9) == 0)
                    send_req(dfs_pkg::OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63), 0);
                else
                    send_req(dfs_pkg::OP_ADD, $urandom_range(0, n - 1),
                             $urandom_range(0, n - 1), $urandom_range(0, 255));
            end
            send_req(dfs_pkg::OP_RUN, 0, 0, 0);
            m = $urandom_range(4, 16);
            for (int i = 0; i < m; i++) begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    send_req(dfs_pkg::OP_RDA, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, arc_cnt + 1));
                else if (pick < 16)
                    send_req(dfs_pkg::OP_RDV, 0, 0, $urandom_range(0, n == 0 ? 1 : n));
                else if (pick < 18)
                    send_req(3'($urandom_range(dfs_pkg::OP_RDV, dfs_pkg::OP_RDA)), 0, 0,
                             $urandom_range(0, 255));
                else
                    send_req(3'($urandom_range(int'(dfs_pkg::OP_CLR) + 1, OP_LAST)),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        errors = 0;
        n_requests = 0;
        n_answers = 0;
        n_runs = 0;
        n_cfg = 0;
        hold_left = 0;
        stall_left = 0;
        idle_on = 1'b1;
        arc_cnt = 0;
        vcount = 64;
        for (int v = 0; v < dfs_pkg::MaxVertices; v++) begin
            vtx_color[v] = dfs_pkg::C_WHITE;
            vtx_disc[v] = 0;
            vtx_fin[v] = 0;
            vtx_par[v] = NoParent;
        end
        for (int i = 0; i < dfs_pkg::MaxArcs; i++) arc_cls[i] = dfs_pkg::K_TREE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_vcount_extremes();
        test_stale_arcs();
        test_backpressure();
        test_full_table();
        test_random(1000);
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d searches, %0d vertex count writes",
                 n_requests, n_runs, n_cfg);
        $display("checked %0d answers, %0d left pending", n_answers, answer_q.size());
        if (errors == 0 && answer_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // stop a hung run
    initial begin
        #30ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/dfs_pkg.sv
hdl/dfs_edge_classifier_unit.sv
verif/tb_dfs_edge_classifier_unit.sv
